// ----- sv/smhpq_pkg.sv -----
package smhpq_pkg;

  localparam int unsigned MaxEntries = 128;
  localparam int unsigned AddrW = $clog2(MaxEntries);
  localparam int unsigned CountW = $clog2(MaxEntries + 1);
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW = 31;
  localparam int unsigned StampW = 32;
  localparam int unsigned EntryW = ValueW + PrioW + StampW;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StBadPrio = 2'd3;

  localparam logic OpInsert = 1'b0;
  localparam logic OpExtract = 1'b1;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
    logic [StampW-1:0] stamp;
  } entry_t;

  // x is served before y
  function automatic logic goes_first(entry_t x, entry_t y);
    if (x.prio != y.prio) begin
      return x.prio < y.prio;
    end
    return x.stamp < y.stamp;
  endfunction

endpackage

// ----- sv/stable_min_heap_priority_queue_core.sv -----
// Binary min-heap priority queue with oldest-first tie-break. Each transaction
// on the input channel is either an insert (value, priority >= 1) or an
// extract-minimum. Each one yields exactly one result transaction. The result
// carries the extracted value (zero otherwise), a status code and the
// occupancy after the operation. Entries are kept in one RAM with one write
// port and one registered read port. The entry being sifted is held in a
// register until it reaches its final slot. Only one transaction is in
// flight at a time.
//
// Steps from accepting a transaction to the next possible accept, when the
// result register is free:
//   - refused operation, or insert into an empty queue: straight to SOut
//   - insert: one compare per level climbed, because the read of the next
//     parent overlaps the write-back
//   - extract: root read, then, unless it was the only entry, the last
//     entry read, then per level descended a left child read and a right
//     child read with compare/write, plus a final write when the entry
//     sinks to a leaf
// The result register loads in SOut, which then returns to SIdle. The single
// read port serialises these reads. A stalled result stays in the output
// register while the core accepts and runs the next transaction. A
// transaction that finishes while that register is still full waits in SOut.
// There is no clearing pass after reset, because the heap only uses
// entries below the fill count. The capacity register (reset 128) limits
// inserts to min(capacity, 128) entries. Write it only while idle.
module stable_min_heap_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic signed [31:0] item_value_i,
  input  logic signed [31:0] item_priority_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] out_value_o,
  output logic [1:0]  status_o,
  output logic [7:0]  occupancy_o
);

  typedef enum logic [7:0] {
    SIdle   = 8'b0000_0001,
    SUpCmp  = 8'b0000_0010,  // parent data in, compare and write back
    SDnRoot = 8'b0000_0100,  // root data in, last entry read issued
    SDnLast = 8'b0000_1000,  // last entry in, becomes sift entry
    SDnL    = 8'b0001_0000,  // left child in, right child read issued
    SDnCmp  = 8'b0010_0000,  // pick child, compare and write back
    SFin    = 8'b0100_0000,  // sift entry written at its final slot
    SOut    = 8'b1000_0000   // result waits for the output register
  } state_e;

  localparam int unsigned AW = smhpq_pkg::AddrW;
  localparam int unsigned ChW = smhpq_pkg::AddrW + 2;  // child index width

  state_e state_q, state_d;
  logic [7:0] cap_q;
  logic [smhpq_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [31:0] stamp_q, stamp_d;
  logic [AW-1:0] idx_q, idx_d;         // sift position
  smhpq_pkg::entry_t cur_q, cur_d;     // entry being sifted
  smhpq_pkg::entry_t lft_q, lft_d;     // left child held while right is read
  logic [31:0] res_val_q, res_val_d;
  logic [1:0]  res_st_q, res_st_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_val_q;
  logic [1:0]  out_st_q;
  logic [7:0]  out_occ_q;
  logic        out_free, out_load;

  logic we;
  logic [AW-1:0] waddr, raddr;
  smhpq_pkg::entry_t wdata, rdata;

  smhpq_ram #(.Width(smhpq_pkg::EntryW), .Depth(smhpq_pkg::MaxEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [AW-1:0] parent_idx, gp_idx;
  logic [ChW-1:0] left_idx, right_idx, best_left, cnt_ext;
  logic [smhpq_pkg::CountW-1:0] limit;
  logic accept, prio_bad;
  smhpq_pkg::entry_t best;
  logic [AW-1:0] best_idx;

  assign parent_idx = (idx_q - AW'(1)) >> 1;
  assign gp_idx = (parent_idx - AW'(1)) >> 1;
  assign left_idx = {1'b0, idx_q, 1'b1};
  assign right_idx = left_idx + ChW'(1);
  assign cnt_ext = ChW'(cnt_q);
  assign limit = (32'(cap_q) < smhpq_pkg::MaxEntries) ?
                 smhpq_pkg::CountW'(cap_q) : smhpq_pkg::CountW'(smhpq_pkg::MaxEntries);
  assign prio_bad = item_priority_i[31] || (item_priority_i == '0);
  assign in_stall_o = (state_q != SIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == SOut) && out_free;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    stamp_d = stamp_q;
    idx_d = idx_q;
    cur_d = cur_q;
    lft_d = lft_q;
    res_val_d = res_val_q;
    res_st_d = res_st_q;
    we = 1'b0;
    waddr = idx_q;
    wdata = cur_q;
    raddr = '0;
    best = lft_q;
    best_idx = AW'(left_idx);
    best_left = {1'b0, best_idx, 1'b1};
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          res_val_d = '0;
          res_st_d = smhpq_pkg::StOk;
          state_d = SOut;
          if (operation_i == smhpq_pkg::OpInsert) begin
            // full wins over a bad priority
            if (cnt_q >= limit) begin
              res_st_d = smhpq_pkg::StFull;
            end else if (prio_bad) begin
              res_st_d = smhpq_pkg::StBadPrio;
            end else begin
              cur_d.value = item_value_i;
              cur_d.prio = item_priority_i[30:0];
              cur_d.stamp = stamp_q;
              stamp_d = stamp_q + 32'd1;
              idx_d = AW'(cnt_q);
              cnt_d = cnt_q + smhpq_pkg::CountW'(1);
              if (cnt_q == '0) begin
                // first entry goes straight to the root
                we = 1'b1;
                waddr = '0;
                wdata = cur_d;
              end else begin
                raddr = AW'((cnt_q - smhpq_pkg::CountW'(1)) >> 1);
                state_d = SUpCmp;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              res_st_d = smhpq_pkg::StEmpty;
            end else begin
              raddr = '0;
              cnt_d = cnt_q - smhpq_pkg::CountW'(1);
              idx_d = '0;
              state_d = SDnRoot;
            end
          end
        end
      end
      SUpCmp: begin
        we = 1'b1;
        if (smhpq_pkg::goes_first(cur_q, rdata)) begin
          // parent moves down, next parent read overlaps the write
          wdata = rdata;
          idx_d = parent_idx;
          if (parent_idx == '0) begin
            state_d = SFin;
          end else begin
            raddr = gp_idx;
          end
        end else begin
          wdata = cur_q;
          state_d = SOut;
        end
      end
      SDnRoot: begin
        // cnt_q already holds the new count, which is the index of the last entry
        res_val_d = rdata.value;
        raddr = AW'(cnt_q);
        state_d = (cnt_q == '0) ? SOut : SDnLast;
      end
      SDnLast: begin
        cur_d = rdata;
        if (left_idx >= cnt_ext) begin
          we = 1'b1;
          wdata = rdata;
          state_d = SOut;
        end else begin
          raddr = AW'(left_idx);
          state_d = SDnL;
        end
      end
      SDnL: begin
        lft_d = rdata;
        // may point past the heap; the data is then ignored
        raddr = AW'(right_idx);
        state_d = SDnCmp;
      end
      SDnCmp: begin
        we = 1'b1;
        if (right_idx < cnt_ext && smhpq_pkg::goes_first(rdata, lft_q)) begin
          best = rdata;
          best_idx = AW'(right_idx);
        end
        best_left = {1'b0, best_idx, 1'b1};
        if (smhpq_pkg::goes_first(cur_q, best)) begin
          wdata = cur_q;
          state_d = SOut;
        end else begin
          wdata = best;
          idx_d = best_idx;
          if (best_left >= cnt_ext) begin
            state_d = SFin;
          end else begin
            raddr = AW'(best_left);
            state_d = SDnL;
          end
        end
      end
      SFin: begin
        we = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cap_q <= 8'd128;
      cnt_q <= '0;
      stamp_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      stamp_q <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    lft_q <= lft_d;
    res_val_q <= res_val_d;
    res_st_q <= res_st_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_st_q <= res_st_q;
      out_occ_q <= 8'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_val_q;
  assign status_o = out_st_q;
  assign occupancy_o = out_occ_q;

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= smhpq_pkg::CountW'(smhpq_pkg::MaxEntries)) else $error("count overflow");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_value_o)
    && $stable(status_o) && $stable(occupancy_o))) else $error("stalled result changed");
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == smhpq_pkg::StEmpty) |-> occupancy_o == '0)
    else $error("empty with entries");
`endif
endmodule

// ----- sv/smhpq_ram.sv -----
module smhpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
